@@ design/rfl_pkg.sv @@
// Shared constants and types for the rename free list.
// No dependencies; imported by rename_free_list_with_rollback_top.
package rfl_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int TAG_W = 6;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY    = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_COMMIT   = 3'd3,
    CMD_ROLLBACK = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_PASTHD = 2'd3
  } status_t;

  // Tag that a ring entry holds after reset: entry i holds tag i+1, last entry 0
  function automatic tag_t ring_rst_val(input ptr_t addr);
    ptr_t nxt;
    nxt = addr + ptr_t'(1);
    return tag_t'(nxt);
  endfunction

endpackage

@@ design/rename_free_list_with_rollback_top.sv @@
// Rename free list with speculative and committed heads over one tag ring.
// Depends on rfl_pkg (sizes, command and status codes, ring reset values).

// One command beat is accepted every cycle unless out_tready stalls a full
// output register, and its result beat is loaded into the output register in
// the next cycle; throughput is one beat per clock, limited by the single
// register stage and that back-pressure. The tag ring is a 64-entry memory
// with one write port (tail) and two registered read ports that prefetch the
// entry after the speculative head and the entry after the committed head;
// the head tags themselves are kept in registers, so allocate, commit and
// rollback need no memory read. Ring entries carry valid bits, so no clearing
// pass is needed after reset. The result reports the tag at the speculative
// head (0 when empty), an empty flag, and a status: duplicate release, allocate
// when empty and commit with nothing pending are dropped and only flagged.
module rename_free_list_with_rollback_top
  import rfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [5:0] tag_in, [7:6] zero
  input  logic [2:0] in_tuser,   // [2:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] head_tag, [6] is_empty, [7] zero
  output logic [1:0] out_tuser   // [1:0] status
);

  // Pointers, counts and presence bitmap
  ptr_t spec_head_r, spec_head_nxt;
  ptr_t commit_head_r, commit_head_nxt;
  ptr_t tail_r, tail_nxt;
  cnt_t spec_cnt_r, spec_cnt_nxt;
  cnt_t commit_cnt_r, commit_cnt_nxt;
  logic [DEPTH-1:0] present_r, present_nxt;

  // Cached tags at the two heads
  tag_t sh_tag_r, sh_tag_nxt;
  tag_t ch_tag_r, ch_tag_nxt;

  // Ring memory, valid bits and prefetch read registers
  tag_t             ring_mem [DEPTH];
  logic [DEPTH-1:0] ring_vld_r;
  ptr_t             rd_s_addr, rd_c_addr;
  tag_t             rd_s_data_r, rd_c_data_r;
  logic             rd_s_vld_r, rd_c_vld_r;
  logic             wr_last_vld_r;
  ptr_t             wr_last_addr_r;
  tag_t             wr_last_tag_r;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  tag_t            out_tag_r, out_tag_nxt;
  logic            out_empty_r, out_empty_nxt;
  status_t         out_st_r, out_st_nxt;

  logic    accept;
  cmd_t    cmd;
  tag_t    tag_in;
  logic    wr_en;
  status_t st;
  ptr_t    spec_succ, commit_succ;
  tag_t    sn_mem, cn_mem, sn_cur, cn_cur;
  tag_t    sh_eff, sn_eff, ch_eff, cn_eff;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser[CMD_W-1:0]);
  assign tag_in    = in_tdata[TAG_W-1:0];

  assign spec_succ   = spec_head_r + ptr_t'(1);
  assign commit_succ = commit_head_r + ptr_t'(1);

  // Resolve the entries after each head: memory data, then the write of the last cycle
  assign sn_mem = rd_s_vld_r ? rd_s_data_r : ring_rst_val(spec_succ);
  assign cn_mem = rd_c_vld_r ? rd_c_data_r : ring_rst_val(commit_succ);
  assign sn_cur = (wr_last_vld_r && wr_last_addr_r == spec_succ) ? wr_last_tag_r : sn_mem;
  assign cn_cur = (wr_last_vld_r && wr_last_addr_r == commit_succ) ? wr_last_tag_r : cn_mem;

  // Forward a release written in this cycle into every view that reads that slot
  assign sh_eff = (wr_en && tail_r == spec_head_r)   ? tag_in : sh_tag_r;
  assign sn_eff = (wr_en && tail_r == spec_succ)     ? tag_in : sn_cur;
  assign ch_eff = (wr_en && tail_r == commit_head_r) ? tag_in : ch_tag_r;
  assign cn_eff = (wr_en && tail_r == commit_succ)   ? tag_in : cn_cur;

  // Decode the command beat and compute the next state
  always_comb begin
    wr_en           = 1'b0;
    st              = ST_OK;
    spec_head_nxt   = spec_head_r;
    commit_head_nxt = commit_head_r;
    tail_nxt        = tail_r;
    spec_cnt_nxt    = spec_cnt_r;
    commit_cnt_nxt  = commit_cnt_r;
    present_nxt     = present_r;
    if (accept) begin
      case (cmd)
        CMD_RELEASE: begin
          // Tags are TAG_W bits wide and DEPTH covers them, so no range check
          if (present_r[tag_in] || commit_cnt_r >= cnt_t'(DEPTH)) begin
            st = ST_DUP;
          end else begin
            wr_en               = 1'b1;
            tail_nxt            = tail_r + ptr_t'(1);
            present_nxt[tag_in] = 1'b1;
            spec_cnt_nxt        = spec_cnt_r + cnt_t'(1);
            commit_cnt_nxt      = commit_cnt_r + cnt_t'(1);
          end
        end
        CMD_ALLOC: begin
          if (spec_cnt_r == '0) begin
            st = ST_EMPTY;
          end else begin
            spec_head_nxt = spec_succ;
            spec_cnt_nxt  = spec_cnt_r - cnt_t'(1);
          end
        end
        CMD_COMMIT: begin
          if (commit_cnt_r <= spec_cnt_r) begin
            st = ST_PASTHD;
          end else begin
            present_nxt[ch_eff] = 1'b0;
            commit_head_nxt     = commit_succ;
            commit_cnt_nxt      = commit_cnt_r - cnt_t'(1);
          end
        end
        CMD_ROLLBACK: begin
          spec_head_nxt = commit_head_r;
          spec_cnt_nxt  = commit_cnt_r;
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  // Pick the tags now sitting at each head
  always_comb begin
    sh_tag_nxt = sh_tag_r;
    ch_tag_nxt = ch_tag_r;
    if (accept) begin
      sh_tag_nxt = sh_eff;
      ch_tag_nxt = ch_eff;
      if (spec_head_nxt == spec_succ && spec_head_nxt != spec_head_r) begin
        sh_tag_nxt = sn_eff;
      end else if (cmd == CMD_ROLLBACK) begin
        sh_tag_nxt = ch_eff;
      end
      if (commit_head_nxt != commit_head_r) begin
        ch_tag_nxt = cn_eff;
      end
    end
  end

  // Build the result beat
  always_comb begin
    out_tag_nxt   = out_tag_r;
    out_empty_nxt = out_empty_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = (spec_cnt_nxt == '0);
      out_tag_nxt   = (spec_cnt_nxt == '0) ? tag_t'(0) : sh_tag_nxt;
      out_st_nxt    = st;
    end
  end

  // Prefetch the entries after the heads the next cycle will see
  assign rd_s_addr = rst_n ? spec_head_nxt + ptr_t'(1) : ptr_t'(1);
  assign rd_c_addr = rst_n ? commit_head_nxt + ptr_t'(1) : ptr_t'(1);

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tail_r] <= tag_in;
    end
    rd_s_data_r    <= ring_mem[rd_s_addr];
    rd_c_data_r    <= ring_mem[rd_c_addr];
    wr_last_addr_r <= tail_r;
    wr_last_tag_r  <= tag_in;
  end

  // Ring valid bits and read-side tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r    <= '0;
      rd_s_vld_r    <= 1'b0;
      rd_c_vld_r    <= 1'b0;
      wr_last_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        ring_vld_r[tail_r] <= 1'b1;
      end
      rd_s_vld_r    <= ring_vld_r[rd_s_addr];
      rd_c_vld_r    <= ring_vld_r[rd_c_addr];
      wr_last_vld_r <= wr_en;
    end
  end

  // Hold pointers, counts, bitmap, head tags and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_head_r   <= '0;
      commit_head_r <= '0;
      tail_r        <= ptr_t'(DEPTH - 1);
      spec_cnt_r    <= cnt_t'(DEPTH - 1);
      commit_cnt_r  <= cnt_t'(DEPTH - 1);
      present_r     <= {{(DEPTH-1){1'b1}}, 1'b0};
      sh_tag_r      <= ring_rst_val('0);
      ch_tag_r      <= ring_rst_val('0);
      out_valid_r   <= 1'b0;
    end else begin
      spec_head_r   <= spec_head_nxt;
      commit_head_r <= commit_head_nxt;
      tail_r        <= tail_nxt;
      spec_cnt_r    <= spec_cnt_nxt;
      commit_cnt_r  <= commit_cnt_nxt;
      present_r     <= present_nxt;
      sh_tag_r      <= sh_tag_nxt;
      ch_tag_r      <= ch_tag_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r   <= out_tag_nxt;
    out_empty_r <= out_empty_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_empty_r, out_tag_r};
  assign out_tuser  = out_st_r;

  // The speculative view never holds more than the committed view
  a_spec_le_commit: assert property (@(posedge clk) disable iff (!rst_n)
    spec_cnt_r <= commit_cnt_r)
    else $error("speculative count exceeds committed count");

  // Bitmap population tracks the committed count
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(commit_cnt_r))
    else $error("presence bitmap out of step with committed count");

  // Tail sits spec_cnt entries past the speculative head
  a_tail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == ptr_t'(spec_head_r + ptr_t'(spec_cnt_r)))
    else $error("tail pointer inconsistent with speculative head");

  // Pending allocations are exactly the gap between the two heads
  a_head_gap: assert property (@(posedge clk) disable iff (!rst_n)
    spec_head_r == ptr_t'(commit_head_r + ptr_t'(commit_cnt_r - spec_cnt_r)))
    else $error("head gap inconsistent with counts");

endmodule
